@@ hdl/ttlc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlc_pkg
// shared types, codes and constants of the ttl lookup cache
// ----------------------------------------------------------------------------
package ttlc_pkg;

    localparam int DEF_CACHE_ENTRIES = 256;
    localparam int DEF_QUEUE_DEPTH   = 64;
    localparam logic [15:0] TTL_RESET = 16'd300;

    localparam logic [2:0] CMD_RESOLVE  = 3'd0;
    localparam logic [2:0] CMD_PEEK     = 3'd1;
    localparam logic [2:0] CMD_FILL     = 3'd2;
    localparam logic [2:0] CMD_COMPLETE = 3'd3;
    localparam logic [2:0] CMD_DEQUEUE  = 3'd4;
    localparam logic [2:0] CMD_TICK     = 3'd5;
    localparam logic [2:0] CMD_CLEAR    = 3'd6;

    localparam logic [1:0] ST_EMPTY    = 2'd0;
    localparam logic [1:0] ST_PENDING  = 2'd1;
    localparam logic [1:0] ST_RESOLVED = 2'd2;
    localparam logic [1:0] ST_FAILED   = 2'd3;

    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_TTL    = 1'b1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [15:0] name_in;
        logic        name_found;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [15:0] name_out;
        logic        queued;
        logic        dropped;
        logic        suppressed;
        logic        take_valid;
        logic [63:0] take_hi;
        logic [63:0] take_lo;
        logic [6:0]  queue_fill;
    } t_rsp;

    typedef struct packed {
        logic        index;
        logic [15:0] data;
    } t_cfg;

    // push / pop request from the cache engine to the queue
    typedef struct packed {
        logic push;
        logic pop;
    } t_qctl;

    // queue status back to the engine
    typedef struct packed {
        logic full;
        logic empty;
    } t_qsts;

endpackage

@@ hdl/ttlc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlc_if
// valid/ready channel carrying one packed payload
// ----------------------------------------------------------------------------
interface ttlc_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/ttlc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlc_queue
// request fifo of 128-bit addresses in one synchronous memory
// ----------------------------------------------------------------------------
module ttlc_queue
    import ttlc_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  t_qctl                         i_ctl,
    input  logic [127:0]                  i_wdata,
    output logic [127:0]                  o_rdata,
    output t_qsts                         o_sts,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_count
);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [127:0]  r_mem [QUEUE_DEPTH];
    logic [QW-1:0] r_head, r_tail;
    logic [CW-1:0] r_count;

    function automatic logic [QW-1:0] wrap_inc(input logic [QW-1:0] p);
        return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !o_sts.full) begin
            r_mem[r_tail] <= i_wdata;
        end
        o_rdata <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctl.push && !o_sts.full) begin
                r_tail  <= wrap_inc(r_tail);
                r_count <= r_count + 1'b1;
            end else if (i_ctl.pop && !o_sts.empty) begin
                r_head  <= wrap_inc(r_head);
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_sts.full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_sts.empty = (r_count == '0);
    assign o_count     = r_count;
endmodule

@@ hdl/ttlc_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlc_engine
// entry memories and the scan sequencer for lookup and victim choice
// ----------------------------------------------------------------------------
module ttlc_engine
    import ttlc_pkg::*;
#(
    parameter int CACHE_ENTRIES = DEF_CACHE_ENTRIES,
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_enable,
    input  logic [15:0]           i_ttl,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  t_req                  i_req,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output t_rsp                  o_rsp
);
    localparam int EW = $clog2(CACHE_ENTRIES);
    localparam int QC = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_WIPE  = 8'b00000010,
        S_SCAN  = 8'b00000100,
        S_DEC   = 8'b00001000,
        S_RD    = 8'b00010000,
        S_WR    = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_LAT   = 8'b10000000
    } t_state;

    // entry memory: state, keys, name and time in one word
    typedef struct packed {
        logic [1:0]  st;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [15:0] name;
        logic [31:0] tm;
    } t_ent;

    t_ent         r_mem [CACHE_ENTRIES];
    t_ent         r_rd;
    logic [EW-1:0] r_raddr;
    logic         r_we;
    logic [EW-1:0] r_waddr;
    t_ent         r_wd;

    t_state       r_state;
    t_req         r_req;
    t_rsp         r_rsp;
    logic [EW:0]  r_ptr;      // address issued
    logic [EW:0]  r_cnt;      // entries examined
    logic [31:0]  r_now;
    logic         r_found, r_has_empty, r_has_stale;
    logic [EW-1:0] r_fidx, r_eidx, r_sidx, r_oidx;
    logic [31:0]  r_otime;
    logic         r_ovalid;
    logic [EW-1:0] r_tgt;

    t_qctl        w_qctl;
    t_qsts        w_qsts;
    logic [127:0] w_qrd;
    logic [QC-1:0] w_qcnt;
    logic         w_qclr;

    ttlc_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_qclr),
        .i_ctl   (w_qctl),
        .i_wdata ({r_req.addr_hi, r_req.addr_lo}),
        .o_rdata (w_qrd),
        .o_sts   (w_qsts),
        .o_count (w_qcnt)
    );

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem[r_waddr] <= r_wd;
        end
        r_rd <= r_mem[r_raddr];
    end

    logic [31:0] w_age;
    logic        w_match;
    assign w_age   = r_now - r_rd.tm;
    assign w_match = (r_rd.st != ST_EMPTY) && (r_rd.hi == r_req.addr_hi)
                     && (r_rd.lo == r_req.addr_lo);

    always_comb begin
        w_qctl.push = 1'b0;
        w_qctl.pop  = 1'b0;
        w_qclr      = 1'b0;
        if (r_state == S_DEC) begin
            w_qclr = (r_req.cmd == CMD_CLEAR);
            w_qctl.pop = (r_req.cmd == CMD_DEQUEUE);
        end else if (r_state == S_WR) begin
            w_qctl.push = r_rsp.queued || r_rsp.dropped;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_OUT);

    // queue count does not move while the result waits
    always_comb begin
        o_rsp            = r_rsp;
        o_rsp.queue_fill = 7'(w_qcnt);
    end

    always_ff @(posedge i_clk) begin
        r_we <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_WIPE;
            r_ptr   <= '0;
            r_now   <= '0;
            r_rsp   <= '0;
            r_found <= 1'b0;
        end else begin
            unique case (r_state)
                S_WIPE: begin
                    r_we    <= 1'b1;
                    r_waddr <= r_ptr[EW-1:0];
                    r_wd    <= '0;
                    r_ptr   <= r_ptr + 1'b1;
                    if (r_ptr == (EW+1)'(CACHE_ENTRIES - 1)) begin
                        r_state <= (r_req.cmd == CMD_CLEAR && r_found) ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_found <= 1'b0;
                    if (i_req_valid) begin
                        r_req       <= i_req;
                        r_rsp       <= '0;
                        r_ptr       <= '0;
                        r_cnt       <= '0;
                        r_has_empty <= 1'b0;
                        r_has_stale <= 1'b0;
                        r_ovalid    <= 1'b0;
                        r_raddr     <= '0;
                        if (i_req.cmd == CMD_RESOLVE || i_req.cmd == CMD_PEEK ||
                            i_req.cmd == CMD_FILL || i_req.cmd == CMD_COMPLETE) begin
                            r_ptr   <= (EW+1)'(1);
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DEC;
                        end
                    end
                end
                S_SCAN: begin
                    // one entry issued and one examined per cycle
                    r_raddr <= r_ptr[EW-1:0];
                    if (r_ptr != (EW+1)'(CACHE_ENTRIES)) r_ptr <= r_ptr + 1'b1;
                    if (r_cnt != '0) begin
                        if (w_match && !r_found) begin
                            r_found <= 1'b1;
                            r_fidx  <= r_cnt[EW-1:0] - 1'b1;
                        end
                        if (r_rd.st == ST_EMPTY && !r_has_empty) begin
                            r_has_empty <= 1'b1;
                            r_eidx      <= r_cnt[EW-1:0] - 1'b1;
                        end
                        if (r_rd.st != ST_PENDING && w_age > {16'd0, i_ttl} &&
                            !r_has_stale) begin
                            r_has_stale <= 1'b1;
                            r_sidx      <= r_cnt[EW-1:0] - 1'b1;
                        end
                        if (!r_ovalid || r_rd.tm < r_otime) begin
                            r_ovalid <= 1'b1;
                            r_otime  <= r_rd.tm;
                            r_oidx   <= r_cnt[EW-1:0] - 1'b1;
                        end
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (EW+1)'(CACHE_ENTRIES)) r_state <= S_RD;
                end
                S_RD: begin
                    r_tgt   <= r_found ? r_fidx : r_has_empty ? r_eidx :
                               r_has_stale ? r_sidx : r_oidx;
                    r_raddr <= r_found ? r_fidx : r_has_empty ? r_eidx :
                               r_has_stale ? r_sidx : r_oidx;
                    r_state <= S_LAT;
                end
                S_LAT: begin
                    // target word is read out of the memory in this cycle
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    // memory word of the target is valid now for scan commands
                    r_state <= S_WR;
                    case (r_req.cmd)
                        CMD_TICK: r_now <= r_now + 1'b1;
                        CMD_DEQUEUE: r_rsp.take_valid <= !w_qsts.empty;
                        CMD_CLEAR: begin
                            r_ptr   <= '0;
                            r_state <= S_WIPE;
                            r_found <= 1'b1;
                        end
                        default: ;
                    endcase
                    if (r_req.cmd == CMD_RESOLVE || r_req.cmd == CMD_PEEK) begin
                        if (r_found && r_rd.st == ST_RESOLVED &&
                            w_age < {16'd0, i_ttl}) begin
                            r_rsp.hit      <= 1'b1;
                            r_rsp.name_out <= r_rd.name;
                        end else if (r_req.cmd == CMD_RESOLVE) begin
                            if (!r_found || r_rd.st == ST_RESOLVED) begin
                                if (!i_enable) begin
                                    r_rsp.suppressed <= 1'b1;
                                end else begin
                                    r_rsp.queued  <= !w_qsts.full;
                                    r_rsp.dropped <= w_qsts.full;
                                    r_we    <= 1'b1;
                                    r_waddr <= r_tgt;
                                    r_wd    <= '{st: ST_PENDING, hi: r_req.addr_hi,
                                                 lo: r_req.addr_lo,
                                                 name: r_found ? r_rd.name : 16'd0,
                                                 tm: r_now};
                                end
                            end
                        end
                    end else if (r_req.cmd == CMD_FILL) begin
                        r_we    <= 1'b1;
                        r_waddr <= r_tgt;
                        r_wd    <= '{st: ST_RESOLVED, hi: r_req.addr_hi,
                                     lo: r_req.addr_lo, name: r_req.name_in, tm: r_now};
                    end else if (r_req.cmd == CMD_COMPLETE) begin
                        if (r_found && r_rd.st == ST_PENDING) begin
                            r_we    <= 1'b1;
                            r_waddr <= r_tgt;
                            r_wd    <= '{st: r_req.name_found ? ST_RESOLVED : ST_FAILED,
                                         hi: r_rd.hi, lo: r_rd.lo,
                                         name: r_req.name_found ? r_req.name_in : r_rd.name,
                                         tm: r_now};
                        end
                    end
                end
                S_WR: begin
                    // queue read data of the popped slot is registered here
                    if (r_rsp.take_valid) begin
                        r_rsp.take_hi <= w_qrd[127:64];
                        r_rsp.take_lo <= w_qrd[63:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_rsp_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hdl/ttl_cache_with_request_queue_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttl_cache_with_request_queue_core
// ttl lookup cache with a request queue
// ----------------------------------------------------------------------------
// channel   dir  payload
// i_req     in   cmd, addr_hi, addr_lo, name_in, name_found
// o_rsp     out  hit, name_out, queued, dropped, suppressed, take_*, queue_fill
// i_cfg     in   index, data
//
// resolve, peek, fill and completion: one pass over the entry memory through
// its single read port, then a read of the target entry
// other commands skip the pass and go straight to decode
// after reset, and after a clear, a sweep over every entry empties
// the entry memory; no item is accepted meanwhile
// one item at a time; the result waits in its register until taken
// ----------------------------------------------------------------------------
module ttl_cache_with_request_queue_core
    import ttlc_pkg::*;
#(
    parameter int CACHE_ENTRIES = DEF_CACHE_ENTRIES,
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ttlc_if.sink   i_req,
    ttlc_if.source o_rsp,
    ttlc_if.sink   i_cfg
);
    logic        r_enable;
    logic [15:0] r_ttl;
    t_rsp        w_rsp;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_ttl    <= TTL_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                REG_ENABLE: r_enable <= i_cfg.data.data[0];
                REG_TTL:    r_ttl    <= i_cfg.data.data;
                default: ;
            endcase
        end
    end

    ttlc_engine #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .QUEUE_DEPTH   (QUEUE_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (r_enable),
        .i_ttl       (r_ttl),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (i_req.data),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp       (w_rsp)
    );

    assign o_rsp.data = w_rsp;
endmodule

@@ hdl/ttlc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlc_checker
// port-level checks of the ttl cache
// ----------------------------------------------------------------------------
module ttlc_checker
    import ttlc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input t_rsp rsp
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !req_ready) else $error("accepting with result pending");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item taken while busy");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> $countones({rsp.hit, rsp.queued, rsp.dropped,
                                  rsp.suppressed, rsp.take_valid}) <= 1)
        else $error("conflicting flags");
    a_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp.hit |-> rsp.name_out == 16'd0)
        else $error("name without hit");
endmodule

bind ttl_cache_with_request_queue_core ttlc_checker u_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .req_valid (i_req.valid),
    .req_ready (i_req.ready),
    .rsp_valid (o_rsp.valid),
    .rsp_ready (o_rsp.ready),
    .rsp       (o_rsp.data)
);
